/* hdl/sql_statement_splitter_defines.svh */
// ----------------------------------------------------------------------------
// sql_statement_splitter_defines.svh
// Assertion macros shared by the statement splitter modules.
// ----------------------------------------------------------------------------
`ifndef SQL_STATEMENT_SPLITTER_DEFINES_SVH
`define SQL_STATEMENT_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define SSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg
// Types, character codes and helpers shared by the statement splitter.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Character codes that steer the splitter.
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Input word kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOI  = 1'b1;

    // Quoting mode of the current statement.
    typedef enum logic [2:0] {
        QUOTE_NONE   = 3'b001,
        QUOTE_SINGLE = 3'b010,
        QUOTE_DOUBLE = 3'b100
    } sss_quote_t;

    // Byte skipping mode: escape pending or inside a comment.
    typedef enum logic [2:0] {
        SKIP_NONE    = 3'b001,
        SKIP_ESCAPE  = 3'b010,
        SKIP_COMMENT = 3'b100
    } sss_skip_t;

    // One result word.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       end_of_input;
        logic       drop_partial;
        logic       quote_newline_warn;
    } sss_word_t;

    // Result word handed from the classifier to the result queue.
    typedef struct packed {
        logic      valid;
        sss_word_t word;
    } sss_push_t;

    // Whitespace that is trimmed before a statement starts.
    function automatic logic is_blank(input logic [7:0] c);
        logic blank;
        blank = c inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_CR};
        return blank;
    endfunction

    // Statement terminators outside quotes.
    function automatic logic is_terminator(input logic [7:0] c);
        logic term;
        term = c inside {CH_SEMI, CH_LBRACE, CH_RBRACE};
        return term;
    endfunction

endpackage

/* hdl/sql_statement_splitter.sv */
// ----------------------------------------------------------------------------
// sql_statement_splitter
// Cuts a byte stream into SQL statements and passes each kept byte out as
// one result word, marking terminators and end of input.
// ----------------------------------------------------------------------------
//  Channel  | Handshake    | Fields
//  ---------+--------------+---------------------------------------------------
//  input    | push / full  | kind, byte_req
//  result   | pop / empty  | ch, last, end_of_input, drop_partial,
//           |              | quote_newline_warn
//
// One input word is taken per cycle; its result, if any, is readable from the
// queue in the next cycle. The classifier decides each word in the cycle it is
// accepted, and the result queue of DEPTH words sets how far the consumer may
// lag before full rises. Reset clears the statement state and empties the
// queue. full stays low while the queue has room, even while pop is held low.
// ----------------------------------------------------------------------------
module sql_statement_splitter
    import sss_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] byte_req,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] ch,
    output logic       last,
    output logic       end_of_input,
    output logic       drop_partial,
    output logic       quote_newline_warn
);

    logic      accept;
    sss_push_t result;
    sss_word_t head;

    assign accept = push && !full;

    // Front part: classification and statement state.
    sss_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind),
        .byte_req (byte_req),
        .result   (result)
    );

    // Back part: result queue toward the consumer.
    sss_result_queue #(
        .DEPTH (DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (result),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head)
    );

    assign ch                 = head.ch;
    assign last               = head.last;
    assign end_of_input       = head.end_of_input;
    assign drop_partial       = head.drop_partial;
    assign quote_newline_warn = head.quote_newline_warn;

endmodule

/* hdl/sss_classify.sv */
// ----------------------------------------------------------------------------
// sss_classify
// Front part: accepts input words, tracks quoting, escape and comment state,
// and decides which result word, if any, each input word produces.
// ----------------------------------------------------------------------------
module sss_classify
    import sss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       kind,
    input  logic [7:0] byte_req,
    output sss_push_t  result
);

`include "sql_statement_splitter_defines.svh"

    sss_quote_t quote_reg, quote_next;
    sss_skip_t  skip_reg, skip_next;
    logic       at_start_reg, at_start_next;
    logic       warned_reg, warned_next;
    logic       emit;
    sss_word_t  word;

    // Per-word decision and next statement state.
    always_comb
    begin
        quote_next    = quote_reg;
        skip_next     = skip_reg;
        at_start_next = at_start_reg;
        warned_next   = warned_reg;
        emit          = 1'b0;
        word          = '0;

        if (kind == KIND_EOI)
        begin
            // End of input: report whether a partial statement was emitted.
            emit              = 1'b1;
            word.end_of_input = 1'b1;
            word.drop_partial = !at_start_reg;
            quote_next        = QUOTE_NONE;
            skip_next         = SKIP_NONE;
            at_start_next     = 1'b1;
            warned_next       = 1'b0;
        end
        else
        begin
            case (skip_reg)
                SKIP_ESCAPE:
                begin
                    // The escaped byte passes through raw.
                    skip_next     = SKIP_NONE;
                    emit          = 1'b1;
                    word.ch       = byte_req;
                    at_start_next = 1'b0;
                end
                SKIP_COMMENT:
                begin
                    if (byte_req == CH_NEWLINE)
                    begin
                        skip_next = SKIP_NONE;
                    end
                end
                default:
                begin
                    if (byte_req == CH_NEWLINE)
                    begin
                        // Newline becomes a space; the first one inside quotes warns.
                        if (quote_reg != QUOTE_NONE && !warned_reg)
                        begin
                            warned_next             = 1'b1;
                            word.quote_newline_warn = 1'b1;
                        end
                        word.ch = CH_SPACE;
                        if (!at_start_reg)
                        begin
                            emit          = 1'b1;
                            at_start_next = 1'b0;
                        end
                    end
                    else if (byte_req == CH_BACKSLASH)
                    begin
                        skip_next     = SKIP_ESCAPE;
                        emit          = 1'b1;
                        word.ch       = byte_req;
                        at_start_next = 1'b0;
                    end
                    else if (quote_reg == QUOTE_NONE && is_terminator(byte_req))
                    begin
                        // Terminator closes the statement and clears its state.
                        emit          = 1'b1;
                        word.ch       = byte_req;
                        word.last     = 1'b1;
                        quote_next    = QUOTE_NONE;
                        skip_next     = SKIP_NONE;
                        at_start_next = 1'b1;
                        warned_next   = 1'b0;
                    end
                    else if (quote_reg == QUOTE_NONE && byte_req == CH_HASH)
                    begin
                        skip_next = SKIP_COMMENT;
                    end
                    else
                    begin
                        // Quote tracking, then the leading whitespace trim.
                        if (quote_reg == QUOTE_NONE)
                        begin
                            if (byte_req == CH_SQUOTE)
                            begin
                                quote_next = QUOTE_SINGLE;
                            end
                            else if (byte_req == CH_DQUOTE)
                            begin
                                quote_next = QUOTE_DOUBLE;
                            end
                        end
                        else if ((quote_reg == QUOTE_SINGLE && byte_req == CH_SQUOTE) ||
                                 (quote_reg == QUOTE_DOUBLE && byte_req == CH_DQUOTE))
                        begin
                            quote_next = QUOTE_NONE;
                        end
                        word.ch = byte_req;
                        if (!(at_start_reg && is_blank(byte_req)))
                        begin
                            emit          = 1'b1;
                            at_start_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // Statement state advances only on an accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg    <= QUOTE_NONE;
            skip_reg     <= SKIP_NONE;
            at_start_reg <= 1'b1;
            warned_reg   <= 1'b0;
        end
        else if (accept)
        begin
            quote_reg    <= quote_next;
            skip_reg     <= skip_next;
            at_start_reg <= at_start_next;
            warned_reg   <= warned_next;
        end
    end

    assign result.valid = accept && emit;
    assign result.word  = word;

    // End of input returns every piece of statement state to its reset value.
    `SSS_ASSERT_NEXT(a_eoi_clears, accept && kind == KIND_EOI, at_start_reg && !warned_reg && quote_reg == QUOTE_NONE && skip_reg == SKIP_NONE, "end of input did not clear statement state")
    // A terminator starts a fresh statement.
    `SSS_ASSERT_NEXT(a_last_restarts, result.valid && result.word.last, at_start_reg && quote_reg == QUOTE_NONE, "terminator did not restart the statement")
    // The quote newline warning is given once and then remembered.
    `SSS_ASSERT_IMPLY(a_warn_once, result.valid && result.word.quote_newline_warn, !warned_reg && quote_reg != QUOTE_NONE, "quote newline warning repeated")

endmodule

/* hdl/sss_result_queue.sv */
// ----------------------------------------------------------------------------
// sss_result_queue
// Back part: a short queue of result words that decouples the classifier
// from the consumer and presents the oldest word on its outputs.
// ----------------------------------------------------------------------------
module sss_result_queue
    import sss_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sss_push_t push_in,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output sss_word_t head
);

`include "sql_statement_splitter_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sss_word_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push_en;
    logic            pop_en;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_en = push_in.valid;
    assign pop_en  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wr_ptr_reg] <= push_in.word;
        end
    end

    // Occupancy never passes the depth.
    `SSS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count above depth")
    // The front never pushes into a full queue.
    `SSS_ASSERT_IMPLY(a_no_overrun, push_en, !full, "push into a full result queue")
    // Without traffic the occupancy holds.
    `SSS_ASSERT_NEXT(a_count_idle, !push_en && !pop_en, count_reg == $past(count_reg), "queue count moved without traffic")

endmodule
